### sv/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared constants and the action code type of the vector ALU.
// ----------------------------------------------------------------------------
package vnorm_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ACT_BITS      = 4;
   localparam int LANES         = 4;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_ADDV,
      ACT_SUBV,
      ACT_MULV,
      ACT_DIVV,
      ACT_ADDS,
      ACT_SUBS,
      ACT_RSUBS,
      ACT_MULS,
      ACT_DIVS,
      ACT_RDIVS,
      ACT_MAG,
      ACT_NORM
   } action_type;

endpackage

### sv/vnorm_sqrt.sv
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vnorm_sqrt #(
   parameter int ROOT_BITS = vnorm_pkg::WORD_BITS_DEF + 1
) (
   input  logic                   clock,
   input  logic [2*ROOT_BITS-1:0] rad,
   output logic [ROOT_BITS-1:0]   root
);
   import vnorm_pkg::*;

   localparam int RW = ROOT_BITS;
   localparam int SW = 2 * RW;
   localparam int MW = RW + 2;

   logic [RW-1:0] root_ff [1:RW];
   logic [MW-1:0] rem_ff  [1:RW];
   logic [SW-1:0] rad_ff  [1:RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW-1:0] root_p;
      logic [MW-1:0] rem_p;
      logic [SW-1:0] rad_p;
      logic [MW+1:0] rem_t;
      logic [MW+1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign root_p = '0;
         assign rem_p  = '0;
         assign rad_p  = rad;
      end else begin : g_next
         assign root_p = root_ff[k];
         assign rem_p  = rem_ff[k];
         assign rad_p  = rad_ff[k];
      end

      assign rem_t = {rem_p, rad_p[SW-1-2*k -: 2]};
      assign trial = {2'b00, root_p, 2'b01};
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? MW'(rem_t - trial) : MW'(rem_t);
         root_ff[k+1] <= {root_p[RW-2:0], ge};
         rad_ff[k+1]  <= rad_p;
      end
   end

   assign root = root_ff[RW];

endmodule

### sv/vnorm_lane.sv
// ----------------------------------------------------------------------------
// vnorm_lane
// One element lane: saturating add/subtract, multiply, and a pipelined
// restoring divider shared by divide and normalize.
// ----------------------------------------------------------------------------
module vnorm_lane #(
   parameter int WORD_BITS = vnorm_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  vnorm_pkg::action_type       act,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   input  logic signed [WORD_BITS-1:0] s,
   input  logic        [WORD_BITS:0]   len,
   output logic signed [WORD_BITS-1:0] r,
   output logic                        zflag
);
   import vnorm_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int LW = W + 1;
   localparam int NW = W + F;
   localparam int PW = 2 * W;
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [1:0] {K_ZERO, K_ADD, K_MUL, K_DIV} kind_type;

   typedef struct packed {
      logic         use_q;
      logic         neg;
      logic         flag;
      logic [W-1:0] simple;
   } meta_type;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
   endfunction

   kind_type     kind;
   logic [W-1:0] add_x, add_y, mul_o, div_num, div_den;
   logic         add_sub, div_norm;
   logic [W:0]   xe, ye, add_sum;
   logic [W-1:0] add_sat, num_mag, zsat;
   logic [LW-1:0] den_mag;
   logic         div_neg, dz;

   always_comb begin
      kind     = K_ZERO;
      add_x    = a;
      add_y    = b;
      add_sub  = 1'b0;
      mul_o    = b;
      div_num  = a;
      div_den  = b;
      div_norm = 1'b0;
      case (act)
         ACT_ADDV:  kind = K_ADD;
         ACT_SUBV:  begin kind = K_ADD; add_sub = 1'b1; end
         ACT_MULV:  kind = K_MUL;
         ACT_DIVV:  kind = K_DIV;
         ACT_ADDS:  begin kind = K_ADD; add_y = s; end
         ACT_SUBS:  begin kind = K_ADD; add_y = s; add_sub = 1'b1; end
         ACT_RSUBS: begin kind = K_ADD; add_x = s; add_y = a; add_sub = 1'b1; end
         ACT_MULS:  begin kind = K_MUL; mul_o = s; end
         ACT_DIVS:  begin kind = K_DIV; div_den = s; end
         ACT_RDIVS: begin kind = K_DIV; div_num = s; div_den = a; end
         ACT_NORM:  begin kind = K_DIV; div_norm = 1'b1; end
         default:   kind = K_ZERO;
      endcase
   end

   assign xe      = {add_x[W-1], add_x};
   assign ye      = {add_y[W-1], add_y};
   assign add_sum = add_sub ? xe - ye : xe + ye;
   assign add_sat = (add_sum[W] != add_sum[W-1]) ? (add_sum[W] ? MINV : MAXV)
                                                 : add_sum[W-1:0];

   assign num_mag = mag_of(div_num);
   assign den_mag = div_norm ? len : {1'b0, mag_of(div_den)};
   assign div_neg = div_norm ? div_num[W-1] : (div_num[W-1] ^ div_den[W-1]);
   assign dz      = den_mag == '0;
   assign zsat    = div_num[W-1] ? MINV : ((num_mag == '0) ? '0 : MAXV);

   // operand stage
   kind_type      s1_kind_ff;
   logic [W-1:0]  s1_add_ff, s1_num_ff, s1_zsat_ff;
   logic [PW-1:0] s1_prod_ff;
   logic [LW-1:0] s1_den_ff;
   logic          s1_neg_ff, s1_dz_ff;

   always_ff @(posedge clock) begin
      s1_kind_ff <= kind;
      s1_add_ff  <= add_sat;
      s1_prod_ff <= PW'(mag_of(a)) * PW'(mag_of(mul_o));
      s1_neg_ff  <= (kind == K_MUL) ? (a[W-1] ^ mul_o[W-1]) : div_neg;
      s1_num_ff  <= num_mag;
      s1_den_ff  <= den_mag;
      s1_dz_ff   <= dz;
      s1_zsat_ff <= zsat;
   end

   logic [PW-1:0] mul_p;
   logic [W-1:0]  mul_sat;
   meta_type      meta0;

   assign mul_p = s1_prod_ff >> F;

   always_comb begin
      if (mul_p[PW-1:W-1] != '0) begin
         mul_sat = s1_neg_ff ? MINV : MAXV;
      end else begin
         mul_sat = s1_neg_ff ? (~mul_p[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : mul_p[W-1:0];
      end
      meta0.use_q = (s1_kind_ff == K_DIV) && !s1_dz_ff;
      meta0.flag  = (s1_kind_ff == K_DIV) && s1_dz_ff;
      meta0.neg   = s1_neg_ff;
      case (s1_kind_ff)
         K_ADD:   meta0.simple = s1_add_ff;
         K_MUL:   meta0.simple = mul_sat;
         K_DIV:   meta0.simple = s1_zsat_ff;
         default: meta0.simple = '0;
      endcase
   end

   // divider, one quotient bit per stage
   logic [LW-1:0] rem_ff  [1:NW];
   logic [NW-1:0] quo_ff  [1:NW];
   logic [W-1:0]  num_ff  [1:NW];
   logic [LW-1:0] den_ff  [1:NW];
   meta_type      meta_ff [1:NW];

   for (genvar k = 0; k < NW; k++) begin : g_div
      logic [LW-1:0] rem_p, den_p;
      logic [NW-1:0] quo_p, n_full;
      logic [W-1:0]  num_p;
      meta_type      meta_p;
      logic [LW:0]   trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign quo_p  = '0;
         assign num_p  = s1_num_ff;
         assign den_p  = s1_den_ff;
         assign meta_p = meta0;
      end else begin : g_next
         assign rem_p  = rem_ff[k];
         assign quo_p  = quo_ff[k];
         assign num_p  = num_ff[k];
         assign den_p  = den_ff[k];
         assign meta_p = meta_ff[k];
      end

      assign n_full = {num_p, {F{1'b0}}};
      assign trial  = {rem_p, n_full[NW-1-k]};
      assign ge     = trial >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? LW'(trial - {1'b0, den_p}) : LW'(trial);
         quo_ff[k+1]  <= {quo_p[NW-2:0], ge};
         num_ff[k+1]  <= num_p;
         den_ff[k+1]  <= den_p;
         meta_ff[k+1] <= meta_p;
      end
   end

   logic [NW-1:0] q;
   logic [W-1:0]  q_sat;
   logic [W-1:0]  r_ff;
   logic          z_ff;

   assign q = quo_ff[NW];

   always_comb begin
      if (q[NW-1:W-1] != '0) begin
         q_sat = meta_ff[NW].neg ? MINV : MAXV;
      end else begin
         q_sat = meta_ff[NW].neg ? (~q[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : q[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= meta_ff[NW].use_q ? q_sat : meta_ff[NW].simple;
      z_ff <= meta_ff[NW].flag;
   end

   assign r     = r_ff;
   assign zflag = z_ff;

endmodule

### sv/vector4_alu_normalize.sv
// ----------------------------------------------------------------------------
// vector4_alu_normalize
// Four-lane fixed-point vector ALU with magnitude and normalize.
// ----------------------------------------------------------------------------
// Takes one request per clock while busy is low and returns one response per
// request, in order. Each request passes through the square-root pipeline (one
// root bit per stage) in series with the four lane dividers (one quotient bit
// per stage). busy is a registered copy of reset: it is high while reset is
// held and falls in the cycle after reset is released. rsp_valid is a
// one-cycle strobe; the receiver cannot stall and must take every response
// when shown.
// ----------------------------------------------------------------------------
module vector4_alu_normalize #(
   parameter int FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = vnorm_pkg::WORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [vnorm_pkg::ACT_BITS-1:0]  req_action,
   input  logic signed [WORD_BITS-1:0]     req_a_x,
   input  logic signed [WORD_BITS-1:0]     req_a_y,
   input  logic signed [WORD_BITS-1:0]     req_a_z,
   input  logic signed [WORD_BITS-1:0]     req_a_w,
   input  logic signed [WORD_BITS-1:0]     req_b_x,
   input  logic signed [WORD_BITS-1:0]     req_b_y,
   input  logic signed [WORD_BITS-1:0]     req_b_z,
   input  logic signed [WORD_BITS-1:0]     req_b_w,
   input  logic signed [WORD_BITS-1:0]     req_scalar,
   output logic                            rsp_valid,
   output logic signed [WORD_BITS-1:0]     rsp_r_x,
   output logic signed [WORD_BITS-1:0]     rsp_r_y,
   output logic signed [WORD_BITS-1:0]     rsp_r_z,
   output logic signed [WORD_BITS-1:0]     rsp_r_w,
   output logic        [WORD_BITS:0]       rsp_length,
   output logic                            rsp_zero_divide
);
   import vnorm_pkg::*;

   localparam int W        = WORD_BITS;
   localparam int RW       = W + 1;
   localparam int NW       = W + FRAC_BITS;
   localparam int SQW      = 2 * W;
   localparam int SW       = 2 * RW;
   localparam int RQ_DEPTH = RW + 3;
   localparam int MD_DEPTH = NW + 2;
   localparam int LAT      = RW + NW + 6;

   typedef struct packed {
      action_type                 act;
      logic [LANES-1:0][W-1:0]    a;
      logic [LANES-1:0][W-1:0]    b;
      logic [W-1:0]               s;
   } req_type;

   typedef struct packed {
      action_type    act;
      logic [RW-1:0] len;
   } mrg_type;

   logic    busy_ff;
   logic    accept;
   req_type req_in;

   assign accept     = start && !busy_ff;
   assign busy       = busy_ff;
   assign req_in.act = action_type'(req_action);
   assign req_in.a   = {req_a_w, req_a_z, req_a_y, req_a_x};
   assign req_in.b   = {req_b_w, req_b_z, req_b_y, req_b_x};
   assign req_in.s   = req_scalar;

   // request line, spans squares, sum and square root
   req_type             rq_ff [0:RQ_DEPTH-1];
   logic [RQ_DEPTH-1:0] rq_vld_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         rq_vld_ff <= '0;
      end else begin
         rq_vld_ff <= {rq_vld_ff[RQ_DEPTH-2:0], accept};
      end
      rq_ff[0] <= req_in;
      for (int i = 1; i < RQ_DEPTH; i++) begin
         rq_ff[i] <= rq_ff[i-1];
      end
   end

   // magnitude of A
   logic [W-1:0]   amag  [LANES];
   logic [SQW-1:0] sq_ff [LANES];
   logic [SW-1:0]  sum_ff;
   logic [RW-1:0]  len;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         amag[i] = rq_ff[0].a[i][W-1] ? (~rq_ff[0].a[i] + {{(W-1){1'b0}}, 1'b1})
                                      : rq_ff[0].a[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         sq_ff[i] <= SQW'(amag[i]) * SQW'(amag[i]);
      end
      sum_ff <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]) + SW'(sq_ff[3]);
   end

   vnorm_sqrt #(.ROOT_BITS(RW)) u_sqrt (
      .clock (clock),
      .rad   (sum_ff),
      .root  (len)
   );

   // element lanes
   logic signed [W-1:0] lane_r [LANES];
   logic [LANES-1:0]    lane_z;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vnorm_lane #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .act   (rq_ff[RQ_DEPTH-1].act),
         .a     (rq_ff[RQ_DEPTH-1].a[i]),
         .b     (rq_ff[RQ_DEPTH-1].b[i]),
         .s     (rq_ff[RQ_DEPTH-1].s),
         .len   (len),
         .r     (lane_r[i]),
         .zflag (lane_z[i])
      );
   end

   // merge
   mrg_type             md_ff [0:MD_DEPTH-1];
   logic [MD_DEPTH-1:0] md_vld_ff;
   logic                rsp_vld_ff;
   logic [W-1:0]        rsp_r_ff [LANES];
   logic [RW-1:0]       rsp_len_ff;
   logic                rsp_zd_ff;
   action_type          rsp_act_ff;
   logic                len_used;

   assign len_used = (md_ff[MD_DEPTH-1].act == ACT_MAG) || (md_ff[MD_DEPTH-1].act == ACT_NORM);

   always_ff @(posedge clock) begin
      if (reset) begin
         md_vld_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         md_vld_ff  <= {md_vld_ff[MD_DEPTH-2:0], rq_vld_ff[RQ_DEPTH-1]};
         rsp_vld_ff <= md_vld_ff[MD_DEPTH-1];
      end
      md_ff[0].act <= rq_ff[RQ_DEPTH-1].act;
      md_ff[0].len <= len;
      for (int i = 1; i < MD_DEPTH; i++) begin
         md_ff[i] <= md_ff[i-1];
      end
      for (int i = 0; i < LANES; i++) begin
         rsp_r_ff[i] <= lane_r[i];
      end
      rsp_len_ff <= len_used ? md_ff[MD_DEPTH-1].len : '0;
      rsp_zd_ff  <= |lane_z;
      rsp_act_ff <= md_ff[MD_DEPTH-1].act;
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_r_x         = rsp_r_ff[0];
   assign rsp_r_y         = rsp_r_ff[1];
   assign rsp_r_z         = rsp_r_ff[2];
   assign rsp_r_w         = rsp_r_ff[3];
   assign rsp_length      = rsp_len_ff;
   assign rsp_zero_divide = rsp_zd_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request lost in pipeline");

   a_len_only_mag: assert property (@(posedge clock)
      rsp_vld_ff && (rsp_len_ff != '0) |-> (rsp_act_ff == ACT_MAG) || (rsp_act_ff == ACT_NORM))
      else $error("length on non-magnitude request");

   a_zero_norm: assert property (@(posedge clock)
      rsp_vld_ff && rsp_zd_ff && (rsp_act_ff == ACT_NORM)
      |-> (rsp_len_ff == '0) && (rsp_r_ff[0] == '0) && (rsp_r_ff[1] == '0)
          && (rsp_r_ff[2] == '0) && (rsp_r_ff[3] == '0))
      else $error("zero vector normalize gave nonzero result");

endmodule
